// ----- rtl/core/adaptive_timestep_select_assert.svh -----
// Assertion macros shared by the time step selector files.
`ifndef ADAPTIVE_TIMESTEP_SELECT_ASSERT_SVH
`define ADAPTIVE_TIMESTEP_SELECT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ATSS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("atss: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ATSS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("atss: next-cycle check failed");

`endif

// ----- rtl/core/atss_pkg.sv -----
package atss_pkg;

    // Particle types and reported results
    localparam int NUM_TYPES   = 2;
    localparam int NUM_RES     = (NUM_TYPES < 2) ? NUM_TYPES : 2;
    localparam int STORE_TYPES = 2;
    localparam int TYPE_W      = 1;

    // Datapath widths
    localparam int VAL_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 64;
    localparam int WIDE_W  = 128;
    localparam int QUOT_W  = 32;
    localparam int CNT_W   = 5;
    localparam int ALARM_W = 46;

    // Configuration port
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_MOVE_LIMIT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ENERGY_LIMIT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FORCE_UNIT   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DT_MAX       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_VEL_UNIT_A   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_VEL_UNIT_B   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TIME_UNIT_A  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_TIME_UNIT_B  = 3'd7;

    localparam logic [VAL_W-1:0] ONE_Q16    = 32'h0001_0000;
    localparam logic [VAL_W-1:0] DT_MAX_RST = 32'hFFFF_FFFF;

    // Growth cap of 1.1 as x + floor(x/10); the tenth is taken as
    // (x * CAP_RECIP) >> CAP_SHIFT, exact for every 32-bit x
    localparam logic [VAL_W-1:0] CAP_RECIP = 32'hCCCC_CCCD;
    localparam int               CAP_SHIFT = 35;

    // Alarm threshold of 1.1001 as an integer ratio
    localparam logic [VAL_W-1:0] ALARM_SCALED_MUL = 32'd10000;
    localparam logic [VAL_W-1:0] ALARM_PREV_MUL   = 32'd11001;

    // Sideband bit positions
    localparam int SU_IS_NEW   = 0;
    localparam int SU_VEL_TYPE = 1;
    localparam int SU_ACC_TYPE = 2;
    localparam int MU_TYPE     = 0;
    localparam int MU_COLL     = 1;
    localparam int MU_ALARM    = 2;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- rtl/core/atss_divider.sv -----
`include "adaptive_timestep_select_assert.svh"

module atss_divider import atss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              div_start,
    input  logic [WIDE_W-1:0] div_num,
    input  logic [WIDE_W-1:0] div_den,
    output logic [QUOT_W-1:0] div_quot,
    output div_stat_t         div_stat
);

    typedef enum logic [2:0] {
        D_IDLE  = 3'b001,
        D_CHECK = 3'b010,
        D_RUN   = 3'b100
    } dstate_t;

    dstate_t             dstate_reg, dstate_next;
    logic [WIDE_W-1:0]   rem_reg, rem_next;
    logic [WIDE_W-1:0]   den_reg, den_next;
    logic [QUOT_W-1:0]   lo_reg, lo_next;
    logic [QUOT_W-1:0]   quot_reg, quot_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;

    logic [WIDE_W:0]     trial;
    logic [WIDE_W:0]     trial_diff;
    logic                trial_ge;

    // One restoring step: bring down the next numerator bit
    assign trial      = {rem_reg, lo_reg[QUOT_W-1]};
    assign trial_ge   = trial >= {1'b0, den_reg};
    assign trial_diff = trial - {1'b0, den_reg};

    // Sequence the check and the quotient bits
    always_comb begin
        dstate_next = dstate_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        lo_next     = lo_reg;
        quot_next   = quot_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        case (dstate_reg)
            D_IDLE: begin
                if (div_start) begin
                    rem_next    = {{QUOT_W{1'b0}}, div_num[WIDE_W-1:QUOT_W]};
                    lo_next     = div_num[QUOT_W-1:0];
                    den_next    = div_den;
                    dstate_next = D_CHECK;
                end
            end
            D_CHECK: begin
                // Saturate when the quotient cannot fit, zero divisor included
                if (rem_reg >= den_reg) begin
                    quot_next   = '1;
                    done_next   = 1'b1;
                    dstate_next = D_IDLE;
                end else begin
                    quot_next   = '0;
                    cnt_next    = CNT_W'(QUOT_W - 1);
                    dstate_next = D_RUN;
                end
            end
            D_RUN: begin
                rem_next  = trial_ge ? trial_diff[WIDE_W-1:0] : trial[WIDE_W-1:0];
                lo_next   = {lo_reg[QUOT_W-2:0], 1'b0};
                quot_next = {quot_reg[QUOT_W-2:0], trial_ge};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    done_next   = 1'b1;
                    dstate_next = D_IDLE;
                end
            end
            default: begin
                dstate_next = D_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dstate_reg <= D_IDLE;
            done_reg   <= 1'b0;
        end else begin
            dstate_reg <= dstate_next;
            done_reg   <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        lo_reg   <= lo_next;
        quot_reg <= quot_next;
        cnt_reg  <= cnt_next;
    end

    assign div_quot      = quot_reg;
    assign div_stat.busy = dstate_reg != D_IDLE;
    assign div_stat.done = done_reg;

    `ATSS_ASSERT_SAME(a_start_idle, aclk, aresetn, div_start, dstate_reg == D_IDLE)
    `ATSS_ASSERT_SAME(a_rem_below_den, aclk, aresetn, dstate_reg == D_RUN, rem_reg < den_reg)
    `ATSS_ASSERT_SAME(a_done_idle, aclk, aresetn, done_reg, dstate_reg == D_IDLE)

endmodule

// ----- rtl/core/adaptive_timestep_select.sv -----
// A pass runs from an accepted word to the last result word loaded; it is shorter
// with zero velocity or acceleration, a new run, or saturating quotients.
// Throughput: one input word per pass; the next word is taken the cycle after the
// last result is loaded. The bit-serial divider sets most of the length of a pass.
// Reset: synchronous, active low; clears the step history and restores the
// configuration registers to their defaults.
`include "adaptive_timestep_select_assert.svh"

module adaptive_timestep_select import atss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,   // max_vel, max_acc
    input  logic [2:0]        s_tuser,   // is_new, vel_type, acc_type
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [95:0]       m_tdata,   // step_real, step_scaled, step_ratio
    output logic [2:0]        m_tuser,   // type_index, in_collision, ratio_alarm
    output logic              m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [VAL_W-1:0]  pwdata,
    output logic [VAL_W-1:0]  prdata,
    output logic              pready
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'h0001,
        S_MVU      = 14'h0002,
        S_MVA      = 14'h0004,
        S_MAF      = 14'h0008,
        S_MWIDE    = 14'h0010,
        S_CAP      = 14'h0020,
        S_CLAMP    = 14'h0040,
        S_SCALE    = 14'h0080,
        S_ALM_A    = 14'h0100,
        S_ALM_B    = 14'h0200,
        S_LOAD     = 14'h0400,
        S_DIV_GO   = 14'h0800,
        S_DIV_WAIT = 14'h1000,
        S_CAP_SET  = 14'h2000
    } state_t;

    typedef enum logic [2:0] {
        OP_VEL,
        OP_COLL,
        OP_SCALE,
        OP_RATIO
    } div_op_t;

    // Configuration registers
    logic [VAL_W-1:0] move_limit_reg, energy_limit_reg, force_unit_reg, dt_max_reg;
    logic [VAL_W-1:0] vel_unit_a_reg, vel_unit_b_reg, time_unit_a_reg, time_unit_b_reg;

    // Sequencer and step history
    state_t               state_reg, state_next;
    div_op_t              div_op_reg, div_op_next;
    logic [TYPE_W-1:0]    type_reg, type_next;
    logic [1:0]           idx_reg, idx_next;
    logic [VAL_W-1:0]     step_now_reg, step_now_next;
    logic [VAL_W-1:0]     step_before_reg, step_before_next;
    logic [VAL_W-1:0]     scaled_steps_reg [STORE_TYPES];
    logic [VAL_W-1:0]     scaled_steps_next [STORE_TYPES];
    logic                 m_tvalid_reg, m_tvalid_next;

    // Working registers
    logic                 is_new_reg, is_new_next;
    logic [VAL_W-1:0]     vel_reg, vel_next;
    logic [VAL_W-1:0]     acc_reg, acc_next;
    logic [VAL_W-1:0]     uv_reg, uv_next;
    logic [VAL_W-1:0]     ua_reg, ua_next;
    logic [VAL_W-1:0]     step_reg, step_next;
    logic                 coll_reg, coll_next;
    logic [PROD_W-1:0]    pa_reg, pa_next;
    logic [PROD_W-1:0]    pf_reg, pf_next;
    logic [WIDE_W-1:0]    wacc_reg, wacc_next;
    logic [WIDE_W-1:0]    div_num_reg, div_num_next;
    logic [WIDE_W-1:0]    div_den_reg, div_den_next;
    logic [VAL_W-1:0]     tenth_reg, tenth_next;
    logic [VAL_W-1:0]     scaled_reg, scaled_next;
    logic [VAL_W-1:0]     prev_reg, prev_next;
    logic [VAL_W-1:0]     ratio_reg, ratio_next;
    logic [ALARM_W-1:0]   ma_reg, ma_next;
    logic [ALARM_W-1:0]   mb_reg, mb_next;
    logic [95:0]          m_tdata_reg, m_tdata_next;
    logic [2:0]           m_tuser_reg, m_tuser_next;
    logic                 m_tlast_reg, m_tlast_next;

    // Shared units
    logic [VAL_W-1:0]     mul_a, mul_b;
    logic [PROD_W-1:0]    mul_p;
    logic [WIDE_W-1:0]    wide_term;
    logic [WIDE_W-1:0]    wide_sum;
    logic                 div_start;
    logic [QUOT_W-1:0]    div_quot;
    div_stat_t            div_stat;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic                 out_free;
    logic                 res_last;
    logic [VAL_W-1:0]     step_clamp;
    logic [VAL_W-1:0]     time_unit;
    logic [VAL_W:0]       cap_sum;
    logic [VAL_W-1:0]     cap_val;

    atss_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .div_start (div_start),
        .div_num   (div_num_reg),
        .div_den   (div_den_reg),
        .div_quot  (div_quot),
        .div_stat  (div_stat)
    );

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb begin
        case (cfg_idx)
            REG_MOVE_LIMIT:   prdata = move_limit_reg;
            REG_ENERGY_LIMIT: prdata = energy_limit_reg;
            REG_FORCE_UNIT:   prdata = force_unit_reg;
            REG_DT_MAX:       prdata = dt_max_reg;
            REG_VEL_UNIT_A:   prdata = vel_unit_a_reg;
            REG_VEL_UNIT_B:   prdata = vel_unit_b_reg;
            REG_TIME_UNIT_A:  prdata = time_unit_a_reg;
            REG_TIME_UNIT_B:  prdata = time_unit_b_reg;
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_limit_reg   <= ONE_Q16;
            energy_limit_reg <= ONE_Q16;
            force_unit_reg   <= ONE_Q16;
            dt_max_reg       <= DT_MAX_RST;
            vel_unit_a_reg   <= ONE_Q16;
            vel_unit_b_reg   <= ONE_Q16;
            time_unit_a_reg  <= ONE_Q16;
            time_unit_b_reg  <= ONE_Q16;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MOVE_LIMIT:   move_limit_reg   <= pwdata;
                REG_ENERGY_LIMIT: energy_limit_reg <= pwdata;
                REG_FORCE_UNIT:   force_unit_reg   <= pwdata;
                REG_DT_MAX:       dt_max_reg       <= pwdata;
                REG_VEL_UNIT_A:   vel_unit_a_reg   <= pwdata;
                REG_VEL_UNIT_B:   vel_unit_b_reg   <= pwdata;
                REG_TIME_UNIT_A:  time_unit_a_reg  <= pwdata;
                REG_TIME_UNIT_B:  time_unit_b_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    // Steer the shared multiplier
    always_comb begin
        case (state_reg)
            S_MVU: begin
                mul_a = vel_reg;
                mul_b = uv_reg;
            end
            S_MVA: begin
                mul_a = vel_reg;
                mul_b = ua_reg;
            end
            S_MAF: begin
                mul_a = acc_reg;
                mul_b = force_unit_reg;
            end
            S_MWIDE: begin
                mul_a = idx_reg[0] ? pf_reg[PROD_W-1:VAL_W] : pf_reg[VAL_W-1:0];
                mul_b = idx_reg[1] ? pa_reg[PROD_W-1:VAL_W] : pa_reg[VAL_W-1:0];
            end
            S_CAP: begin
                mul_a = step_before_reg;
                mul_b = CAP_RECIP;
            end
            S_ALM_A: begin
                mul_a = scaled_reg;
                mul_b = ALARM_SCALED_MUL;
            end
            S_ALM_B: begin
                mul_a = prev_reg;
                mul_b = ALARM_PREV_MUL;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Place each partial product of the 64 by 64 divisor product
    always_comb begin
        case (idx_reg)
            2'd0:    wide_term = {{PROD_W{1'b0}}, mul_p};
            2'd3:    wide_term = {mul_p, {PROD_W{1'b0}}};
            default: wide_term = {{VAL_W{1'b0}}, mul_p, {VAL_W{1'b0}}};
        endcase
    end

    assign wide_sum   = wacc_reg + wide_term;
    assign div_start  = state_reg == S_DIV_GO;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign res_last   = type_reg == TYPE_W'(NUM_RES - 1);
    assign step_clamp = (step_reg > dt_max_reg) ? dt_max_reg : step_reg;
    assign time_unit  = type_reg[0] ? time_unit_b_reg : time_unit_a_reg;

    // Growth cap: previous step plus a tenth, saturated to 32 bits
    assign cap_sum = {1'b0, step_before_reg} + {1'b0, tenth_reg};
    assign cap_val = cap_sum[VAL_W] ? '1 : cap_sum[VAL_W-1:0];

    // Sequencer
    always_comb begin
        state_next        = state_reg;
        div_op_next       = div_op_reg;
        type_next         = type_reg;
        idx_next          = idx_reg;
        step_now_next     = step_now_reg;
        step_before_next  = step_before_reg;
        scaled_steps_next = scaled_steps_reg;
        m_tvalid_next     = m_tvalid_reg;
        is_new_next       = is_new_reg;
        vel_next          = vel_reg;
        acc_next          = acc_reg;
        uv_next           = uv_reg;
        ua_next           = ua_reg;
        step_next         = step_reg;
        coll_next         = coll_reg;
        pa_next           = pa_reg;
        pf_next           = pf_reg;
        wacc_next         = wacc_reg;
        div_num_next      = div_num_reg;
        div_den_next      = div_den_reg;
        tenth_next        = tenth_reg;
        scaled_next       = scaled_reg;
        prev_next         = prev_reg;
        ratio_next        = ratio_reg;
        ma_next           = ma_reg;
        mb_next           = mb_reg;
        m_tdata_next      = m_tdata_reg;
        m_tuser_next      = m_tuser_reg;
        m_tlast_next      = m_tlast_reg;

        // Drop the result word once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    is_new_next      = s_tuser[SU_IS_NEW];
                    vel_next         = s_tdata[VAL_W-1:0];
                    acc_next         = s_tdata[2*VAL_W-1:VAL_W];
                    uv_next          = s_tuser[SU_VEL_TYPE] ? vel_unit_b_reg : vel_unit_a_reg;
                    ua_next          = s_tuser[SU_ACC_TYPE] ? vel_unit_b_reg : vel_unit_a_reg;
                    step_before_next = step_now_reg;
                    step_next        = step_now_reg;
                    coll_next        = 1'b0;
                    state_next       = S_MVU;
                end
            end
            S_MVU: begin
                // Zero velocity keeps the old step and rules out a collision step
                if (vel_reg == '0) begin
                    state_next = S_CAP;
                end else begin
                    div_num_next = {{PROD_W{1'b0}}, move_limit_reg, {VAL_W{1'b0}}};
                    div_den_next = {{PROD_W{1'b0}}, mul_p};
                    div_op_next  = OP_VEL;
                    state_next   = S_DIV_GO;
                end
            end
            S_MVA: begin
                pa_next    = mul_p;
                state_next = S_MAF;
            end
            S_MAF: begin
                pf_next    = mul_p;
                wacc_next  = '0;
                idx_next   = '0;
                state_next = S_MWIDE;
            end
            S_MWIDE: begin
                wacc_next = wide_sum;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == 2'd3) begin
                    div_num_next = {{(WIDE_W - VAL_W - PROD_W){1'b0}}, energy_limit_reg,
                                    {PROD_W{1'b0}}};
                    div_den_next = wide_sum;
                    div_op_next  = OP_COLL;
                    state_next   = S_DIV_GO;
                end
            end
            S_CAP: begin
                // Growth cap applies only within a run; take a tenth of the old step
                if (is_new_reg) begin
                    state_next = S_CLAMP;
                end else begin
                    tenth_next = {{(CAP_SHIFT - VAL_W){1'b0}}, mul_p[PROD_W-1:CAP_SHIFT]};
                    state_next = S_CAP_SET;
                end
            end
            S_CAP_SET: begin
                if (step_reg > cap_val) begin
                    step_next = cap_val;
                end
                state_next = S_CLAMP;
            end
            S_CLAMP: begin
                step_next     = step_clamp;
                step_now_next = step_clamp;
                type_next     = '0;
                state_next    = S_SCALE;
            end
            S_SCALE: begin
                div_num_next = {{(WIDE_W - VAL_W - FRAC_W){1'b0}}, step_reg, {FRAC_W{1'b0}}};
                div_den_next = {{(WIDE_W - VAL_W){1'b0}}, time_unit};
                div_op_next  = OP_SCALE;
                state_next   = S_DIV_GO;
            end
            S_DIV_GO: begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_stat.done) begin
                    case (div_op_reg)
                        OP_VEL: begin
                            step_next  = div_quot;
                            state_next = (acc_reg != '0) ? S_MVA : S_CAP;
                        end
                        OP_COLL: begin
                            if (div_quot < step_reg) begin
                                step_next = div_quot;
                                coll_next = 1'b1;
                            end
                            state_next = S_CAP;
                        end
                        OP_SCALE: begin
                            // Swap the stored scaled step and start the ratio
                            scaled_next                 = div_quot;
                            prev_next                   = scaled_steps_reg[type_reg];
                            scaled_steps_next[type_reg] = div_quot;
                            div_num_next = {{(WIDE_W - VAL_W - FRAC_W){1'b0}}, div_quot,
                                            {FRAC_W{1'b0}}};
                            div_den_next = {{(WIDE_W - VAL_W){1'b0}},
                                            scaled_steps_reg[type_reg]};
                            div_op_next  = OP_RATIO;
                            state_next   = S_DIV_GO;
                        end
                        OP_RATIO: begin
                            ratio_next = div_quot;
                            state_next = S_ALM_A;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ALM_A: begin
                ma_next    = mul_p[ALARM_W-1:0];
                state_next = S_ALM_B;
            end
            S_ALM_B: begin
                mb_next    = mul_p[ALARM_W-1:0];
                state_next = S_LOAD;
            end
            S_LOAD: begin
                // Hold until the output register is free
                if (out_free) begin
                    m_tvalid_next          = 1'b1;
                    m_tdata_next           = {ratio_reg, scaled_reg, step_reg};
                    m_tuser_next[MU_TYPE]  = type_reg[0];
                    m_tuser_next[MU_COLL]  = coll_reg;
                    m_tuser_next[MU_ALARM] = !is_new_reg && (ma_reg > mb_reg);
                    m_tlast_next           = res_last;
                    if (res_last) begin
                        state_next = S_IDLE;
                    end else begin
                        type_next  = type_reg + 1'b1;
                        state_next = S_SCALE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and step history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            div_op_reg       <= OP_VEL;
            type_reg         <= '0;
            idx_reg          <= '0;
            step_now_reg     <= '0;
            step_before_reg  <= '0;
            scaled_steps_reg <= '{default: '0};
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            div_op_reg       <= div_op_next;
            type_reg         <= type_next;
            idx_reg          <= idx_next;
            step_now_reg     <= step_now_next;
            step_before_reg  <= step_before_next;
            scaled_steps_reg <= scaled_steps_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        is_new_reg  <= is_new_next;
        vel_reg     <= vel_next;
        acc_reg     <= acc_next;
        uv_reg      <= uv_next;
        ua_reg      <= ua_next;
        step_reg    <= step_next;
        coll_reg    <= coll_next;
        pa_reg      <= pa_next;
        pf_reg      <= pf_next;
        wacc_reg    <= wacc_next;
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        tenth_reg   <= tenth_next;
        scaled_reg  <= scaled_next;
        prev_reg    <= prev_next;
        ratio_reg   <= ratio_next;
        ma_reg      <= ma_next;
        mb_reg      <= mb_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `ATSS_ASSERT_NEXT(a_one_word_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `ATSS_ASSERT_SAME(a_step_clamped, aclk, aresetn, state_reg == S_SCALE, step_reg <= dt_max_reg)
    `ATSS_ASSERT_SAME(a_idle_div_free, aclk, aresetn, state_reg == S_IDLE, !div_stat.busy)

endmodule

// ----- verif/atss_step_checker.sv -----
`timescale 1ns / 1ps

// Watches the configuration port and both stream channels of the time step
// selector, predicts the two per-type result words of every accepted input
// word and compares them, in order, with the words the block hands over.
module atss_step_checker import atss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [63:0]       s_tdata,   // max_vel, max_acc
    input  logic [2:0]        s_tuser,   // is_new, vel_type, acc_type
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [95:0]       m_tdata,   // step_real, step_scaled, step_ratio
    input  logic [2:0]        m_tuser,   // type_index, in_collision, ratio_alarm
    input  logic              m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [VAL_W-1:0]  pwdata,
    input  logic              pready,
    output int                mismatch_count,
    output int                reports_pending
);

    // Growth cap of 1.1 and alarm threshold of 1.1001 as exact ratios
    localparam logic [63:0] GROWTH_NUM = 64'd11;
    localparam logic [63:0] GROWTH_DEN = 64'd10;
    localparam logic [63:0] ALARM_NUM  = 64'd11001;
    localparam logic [63:0] ALARM_DEN  = 64'd10000;
    localparam int          LOG_LIMIT  = 100;

    typedef struct packed {
        logic        type_index;
        logic [31:0] step_real;
        logic [31:0] step_scaled;
        logic [31:0] step_ratio;
        logic        in_collision;
        logic        ratio_alarm;
        logic        last;
    } step_report_t;

    // Shadow configuration
    logic [31:0] move_limit, energy_limit, force_unit, dt_max;
    logic [31:0] vel_unit_a, vel_unit_b, time_unit_a, time_unit_b;

    // Shadow step history
    logic [31:0] step_now, step_before;
    logic [31:0] scaled_hist [2];

    step_report_t reports_due [$];

    // Floor quotient, saturated to 32 bits; a zero divisor saturates too
    function automatic logic [31:0] sat_quotient(input logic [127:0] num,
                                                 input logic [127:0] den);
        logic [127:0] q;
        if (den == '0) return '1;
        q = num / den;
        if (q > 128'hFFFF_FFFF) return '1;
        return q[31:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        // keep the log short when the block is badly off
        if (mismatch_count < LOG_LIMIT)
            $display("%0t ns  timestep check: %s got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic apply_write(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
        case (addr[ADDR_W-1:2])
            REG_MOVE_LIMIT:   move_limit   = value;
            REG_ENERGY_LIMIT: energy_limit = value;
            REG_FORCE_UNIT:   force_unit   = value;
            REG_DT_MAX:       dt_max       = value;
            REG_VEL_UNIT_A:   vel_unit_a   = value;
            REG_VEL_UNIT_B:   vel_unit_b   = value;
            REG_TIME_UNIT_A:  time_unit_a  = value;
            REG_TIME_UNIT_B:  time_unit_b  = value;
            default: ;
        endcase
    endtask

    task automatic predict_timestep(input logic new_run, input logic [31:0] vel,
                                    input logic [31:0] acc, input logic vel_type,
                                    input logic acc_type);
        logic [31:0]  uv, ua, step, coll, prev, scaled, ratio, tu;
        logic [63:0]  cap;
        logic [127:0] den;
        logic         collide, alarm;
        step_report_t rep;
        uv = vel_type ? vel_unit_b : vel_unit_a;
        ua = acc_type ? vel_unit_b : vel_unit_a;
        step_before = step_now;
        step = step_now;
        collide = 1'b0;

        // velocity criterion; zero velocity keeps the old step
        if (vel != '0)
            step = sat_quotient({64'd0, move_limit, 32'd0}, {96'd0, vel} * {96'd0, uv});

        // collision criterion wins only when strictly smaller
        if (vel != '0 && acc != '0) begin
            den = ({96'd0, acc} * {96'd0, force_unit}) * ({96'd0, vel} * {96'd0, ua});
            coll = sat_quotient({32'd0, energy_limit, 64'd0}, den);
            if (coll < step) begin
                step = coll;
                collide = 1'b1;
            end
        end

        // limit growth inside a run, then clamp to the largest step
        if (!new_run) begin
            cap = ({32'd0, step_before} * GROWTH_NUM) / GROWTH_DEN;
            if (cap > 64'hFFFF_FFFF) cap = 64'hFFFF_FFFF;
            if ({32'd0, step} > cap) step = cap[31:0];
        end
        if (step > dt_max) step = dt_max;
        step_now = step;

        // one report per particle type
        for (int i = 0; i < NUM_RES; i++) begin
            tu = (i == 0) ? time_unit_a : time_unit_b;
            prev = scaled_hist[i];
            scaled = sat_quotient({80'd0, step, 16'd0}, {96'd0, tu});
            scaled_hist[i] = scaled;
            if (prev == '0)
                ratio = '1;
            else
                ratio = sat_quotient({80'd0, scaled, 16'd0}, {96'd0, prev});
            alarm = !new_run && ({32'd0, scaled} * ALARM_DEN > {32'd0, prev} * ALARM_NUM);
            rep.type_index   = i[0];
            rep.step_real    = step;
            rep.step_scaled  = scaled;
            rep.step_ratio   = ratio;
            rep.in_collision = collide;
            rep.ratio_alarm  = alarm;
            rep.last         = (i == NUM_RES - 1);
            reports_due.push_back(rep);
        end
    endtask

    task automatic check_report();
        step_report_t want;
        if (reports_due.size() == 0) begin
            report_mismatch("result word with none due, step_real", m_tdata[31:0], '0);
            return;
        end
        want = reports_due.pop_front();
        if (m_tuser[MU_TYPE] !== want.type_index)
            report_mismatch("type_index", 32'(m_tuser[MU_TYPE]), 32'(want.type_index));
        if (m_tdata[31:0] !== want.step_real)
            report_mismatch("step_real", m_tdata[31:0], want.step_real);
        if (m_tdata[63:32] !== want.step_scaled)
            report_mismatch("step_scaled", m_tdata[63:32], want.step_scaled);
        if (m_tdata[95:64] !== want.step_ratio)
            report_mismatch("step_ratio", m_tdata[95:64], want.step_ratio);
        if (m_tuser[MU_COLL] !== want.in_collision)
            report_mismatch("in_collision", 32'(m_tuser[MU_COLL]), 32'(want.in_collision));
        if (m_tuser[MU_ALARM] !== want.ratio_alarm)
            report_mismatch("ratio_alarm", 32'(m_tuser[MU_ALARM]), 32'(want.ratio_alarm));
        if (m_tlast !== want.last)
            report_mismatch("last", 32'(m_tlast), 32'(want.last));
    endtask

    // Sample all channels at the clock edge: register writes, then input
    // words, then result words
    always @(posedge aclk) begin
        if (!aresetn) begin
            move_limit   = 32'h0001_0000;
            energy_limit = 32'h0001_0000;
            force_unit   = 32'h0001_0000;
            dt_max       = 32'hFFFF_FFFF;
            vel_unit_a   = 32'h0001_0000;
            vel_unit_b   = 32'h0001_0000;
            time_unit_a  = 32'h0001_0000;
            time_unit_b  = 32'h0001_0000;
            step_now     = '0;
            step_before  = '0;
            scaled_hist[0] = '0;
            scaled_hist[1] = '0;
            reports_due.delete();
        end else begin
            if (psel && penable && pwrite && pready)
                apply_write(paddr, pwdata);
            if (s_tvalid && s_tready)
                predict_timestep(s_tuser[SU_IS_NEW], s_tdata[31:0], s_tdata[63:32],
                                 s_tuser[SU_VEL_TYPE], s_tuser[SU_ACC_TYPE]);
            if (m_tvalid && m_tready)
                check_report();
        end
        reports_pending <= reports_due.size();
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb import atss_pkg::*; ();

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

    localparam int NUM_REGS     = int'(REG_TIME_UNIT_B) + 1;
    localparam int DRAIN_CYCLES = 300;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [63:0]       s_tdata  = '0;   // max_vel, max_acc
    logic [2:0]        s_tuser  = '0;   // is_new, vel_type, acc_type
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [95:0]       m_tdata;         // step_real, step_scaled, step_ratio
    logic [2:0]        m_tuser;         // type_index, in_collision, ratio_alarm
    logic              m_tlast;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [VAL_W-1:0]  pwdata   = '0;
    logic [VAL_W-1:0]  prdata;
    logic              pready;

    int          mismatch_count;
    int          reports_pending;
    int          src_idle_pct  = 0;
    int          sink_stall_pct = 0;
    logic [31:0] reg_plan [NUM_REGS];

    adaptive_timestep_select u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    atss_step_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .reports_pending (reports_pending)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Receiver: stall at random with the current pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Mix of zero, all ones, full random, scaled random and powers of two plus a random offset
    function automatic logic [31:0] pick_q16();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom;
            4:       return $urandom >> $urandom_range(31);
            default: return (32'h1 << $urandom_range(31)) + ($urandom >> $urandom_range(8, 31));
        endcase
    endfunction

    // Mostly units near 1.0, with the extremes now and then
    function automatic logic [31:0] pick_setting();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            default: return $urandom_range(32'h0000_4000, 32'h0004_0000);
        endcase
    endfunction

    // Drift a value by up to an eighth either way, with an occasional jump
    function automatic logic [31:0] drift(input logic [31:0] v);
        logic [63:0] w;
        if ($urandom_range(19) == 0) return pick_q16();
        w = ({32'd0, v} * 64'($urandom_range(448, 576))) >> 9;
        if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
        return w[31:0];
    endfunction

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SRC:  begin src_idle_pct = 51; sink_stall_pct = 0;  end
            IDLE_SINK: begin src_idle_pct = 0;  sink_stall_pct = 51; end
            default:   begin src_idle_pct = 36; sink_stall_pct = 36; end
        endcase
    endtask

    // Offer one word, idling first as the pressure asks, and hold until taken
    task automatic push_word(input logic new_run, input logic [31:0] vel,
                             input logic [31:0] acc, input logic vel_type,
                             input logic acc_type);
        logic [2:0] side;
        int         gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        // occasional long pause so gaps land on every stage of a pass
        if (src_idle_pct != 0 && $urandom_range(15) == 0) gap += $urandom_range(1, 270);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        side = '0;
        side[SU_IS_NEW]   = new_run;
        side[SU_VEL_TYPE] = vel_type;
        side[SU_ACC_TYPE] = acc_type;
        s_tvalid <= 1'b1;
        s_tdata  <= {acc, vel};
        s_tuser  <= side;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid and wait until every due result word has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (reports_pending != 0);
    endtask

    // Write every register from reg_plan, back to back
    task automatic program_regs();
        for (int i = 0; i < NUM_REGS; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_W'(i * 4);
            pwdata  <= reg_plan[i];
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic plan_random_regs();
        reg_plan[REG_MOVE_LIMIT]   = pick_setting();
        reg_plan[REG_ENERGY_LIMIT] = pick_setting();
        reg_plan[REG_FORCE_UNIT]   = pick_setting();
        reg_plan[REG_DT_MAX]       = ($urandom_range(3) == 0) ? pick_setting() : $urandom;
        reg_plan[REG_VEL_UNIT_A]   = pick_setting();
        reg_plan[REG_VEL_UNIT_B]   = pick_setting();
        reg_plan[REG_TIME_UNIT_A]  = pick_setting();
        reg_plan[REG_TIME_UNIT_B]  = pick_setting();
        if (reg_plan[REG_TIME_UNIT_A] == '0) reg_plan[REG_TIME_UNIT_A] = 32'd1;
        if (reg_plan[REG_TIME_UNIT_B] == '0) reg_plan[REG_TIME_UNIT_B] = 32'd1;
    endtask

    // Runs of one new-run word and drifting follow-ups, with stray words mixed in
    task automatic run_traffic(input int n_items);
        int          run_left;
        logic [31:0] vel, acc;
        run_left = 0;
        vel = '0;
        acc = '0;
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(9) == 0) begin
                push_word(1'($urandom_range(1)), $urandom, $urandom,
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            end else if (run_left == 0) begin
                run_left = $urandom_range(1, 24);
                vel = pick_q16();
                acc = pick_q16();
                push_word(1'b1, vel, acc, 1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
                run_left--;
                vel = drift(vel);
                acc = drift(acc);
                push_word(1'b0, vel, acc, 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words under the reset settings, no idling
        set_idling(IDLE_NONE);
        push_word(1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0); // zero velocity
        push_word(1'b1, ONE_Q16,       32'h0000_0000, 1'b0, 1'b0); // zero acceleration
        push_word(1'b0, ONE_Q16,       ONE_Q16,       1'b0, 1'b0); // tie, no collision
        push_word(1'b0, ONE_Q16,       32'h0002_0000, 1'b1, 1'b1); // collision wins
        push_word(1'b0, 32'h0000_8000, 32'h0000_0000, 1'b0, 1'b1); // growth capped
        push_word(1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0); // zero velocity keeps step
        push_word(1'b0, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0); // saturated quotient, cap
        push_word(1'b1, 32'h0000_0001, 32'h0000_0000, 1'b1, 1'b1); // saturated, new run
        push_word(1'b0, 32'h0000_0001, 32'h0000_0001, 1'b0, 1'b1); // both saturate, tie
        push_word(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1); // step falls to zero
        push_word(1'b0, ONE_Q16,       32'h0000_0000, 1'b0, 1'b0); // cap from a zero step
        push_word(1'b1, ONE_Q16,       32'h0000_0000, 1'b1, 1'b0); // restart, zero previous
        push_word(1'b0, ONE_Q16,       32'h0000_0000, 1'b0, 1'b0); // ratio of exactly one
        push_word(1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1); // sharp drop
        push_word(1'b0, ONE_Q16,       32'h0000_0000, 1'b0, 1'b0); // regrowth capped
        push_word(1'b1, 32'hFFFF_0000, 32'h0000_FFFF, 1'b1, 1'b0);
        push_word(1'b0, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
        push_word(1'b1, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 1'b0); // collision far smaller
        run_traffic(200);

        // Every register at its top value
        wait_drained();
        foreach (reg_plan[i]) reg_plan[i] = '1;
        program_regs();
        set_idling(IDLE_SRC);
        run_traffic(60);

        // Every register at its bottom value, the time units at one
        wait_drained();
        reg_plan[REG_MOVE_LIMIT]   = '0;
        reg_plan[REG_ENERGY_LIMIT] = '0;
        reg_plan[REG_FORCE_UNIT]   = '0;
        reg_plan[REG_DT_MAX]       = '0;
        reg_plan[REG_VEL_UNIT_A]   = '0;
        reg_plan[REG_VEL_UNIT_B]   = '0;
        reg_plan[REG_TIME_UNIT_A]  = 32'd1;
        reg_plan[REG_TIME_UNIT_B]  = 32'd1;
        program_regs();
        set_idling(IDLE_SINK);
        run_traffic(60);

        // Random settings, one per idling mode
        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            plan_random_regs();
            program_regs();
            set_idling(idle_mode_t'((ph + 3) % 4));
            run_traffic(375);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && reports_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
